[design/pt1000_resistance_ratio_to_temperature_unit_macros.svh]
// ----------------------------------------------------------------------------
// pt1k assertion macros
// shared helpers for the port-level checks of the temperature unit
// ----------------------------------------------------------------------------
`ifndef PT1000_RESISTANCE_RATIO_TO_TEMPERATURE_UNIT_MACROS_SVH
`define PT1000_RESISTANCE_RATIO_TO_TEMPERATURE_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define PT1K_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pt1k check failed");

// next-cycle implication, sampled on clk, off during rst
`define PT1K_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pt1k check failed");

`endif

[design/pt1k_pkg.sv]
// ----------------------------------------------------------------------------
// pt1k_pkg
// constants, codes and types of the pt1000 ratio to temperature unit
// ----------------------------------------------------------------------------
package pt1k_pkg;

  // ratio quotient: 3 integer bits, 28 fraction bits
  localparam int QUO_W      = 31;
  localparam int DIV_STEPS  = QUO_W;
  localparam int SQRT_STEPS = 32;

  // discriminant times 1e14, Q32
  localparam logic [27:0] DISC_SLOPE = 28'd231000000;
  localparam logic [63:0] DISC_BASE  = {32'd1758480889, 32'd0};

  // A times 1e7, Q16
  localparam logic [31:0] A16 = 32'd2561343488;

  // scaling: t = round(mag * 5120 / (231 * 2^16)) = floor((5*mag + 7392) / 64 / 231)
  localparam logic [35:0] ROUND_BIAS  = 36'd7392;
  localparam logic [30:0] RECIP_K     = 31'd1189947649;  // floor(2^38 / 231)
  localparam int          RECIP_SHIFT = 38;
  localparam logic [7:0]  DIV_CONST   = 8'd231;

  localparam logic signed [23:0] T22_MAX = 24'sd2097151;
  localparam logic signed [23:0] T22_MIN = -24'sd2097152;

  // configuration register indexes
  typedef enum logic {
    CFG_WINDOW_LOW  = 1'b0,
    CFG_WINDOW_HIGH = 1'b1
  } cfg_index_t;

  // tag that travels with every pipeline slot
  typedef struct packed {
    logic valid;
    logic bad;
  } tag_t;

endpackage

[design/pt1k_in_if.sv]
// ----------------------------------------------------------------------------
// pt1k_in_if
// request channel carrying the two measured times
// ----------------------------------------------------------------------------
interface pt1k_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] measured_time;
  logic [31:0] reference_time;

  modport source (output valid, measured_time, reference_time, input ready);
  modport sink   (input valid, measured_time, reference_time, output ready);
endinterface

[design/pt1k_out_if.sv]
// ----------------------------------------------------------------------------
// pt1k_out_if
// result channel carrying the temperature and its flags
// ----------------------------------------------------------------------------
interface pt1k_out_if;
  logic               valid;
  logic               ready;
  logic signed [21:0] temperature_q8;
  logic               second_root_used;
  logic               invalid;

  modport source (output valid, temperature_q8, second_root_used, invalid, input ready);
  modport sink   (input valid, temperature_q8, second_root_used, invalid, output ready);
endinterface

[design/pt1k_divider.sv]
// ----------------------------------------------------------------------------
// pt1k_divider
// pipelined restoring divider, one quotient bit per stage: m * 2^28 / ref
// ----------------------------------------------------------------------------
module pt1k_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  pt1k_pkg::tag_t            tag_in,
  input  logic [31:0]               m,
  input  logic [31:0]               ref_val,
  output pt1k_pkg::tag_t            tag_out,
  output logic [pt1k_pkg::QUO_W-1:0] quo_out
);

  localparam int N = pt1k_pkg::DIV_STEPS;

  pt1k_pkg::tag_t            tag  [0:N];
  logic [31:0]               rem  [0:N];
  logic [31:0]               dvs  [0:N];
  logic [2:0]                mlow [0:N];
  logic [pt1k_pkg::QUO_W-1:0] quo [0:N];

  // load stage: top bits of the dividend form the first remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      tag[0] <= '0;
    end else if (en) begin
      tag[0] <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= {3'b000, m[31:3]};
      dvs[0]  <= ref_val;
      mlow[0] <= m[2:0];
      quo[0]  <= '0;
    end
  end

  // one shift and trial subtract per stage
  for (genvar k = 1; k <= N; k++) begin : g_step
    logic [32:0] shifted;
    logic        take;

    assign shifted = {rem[k-1], mlow[k-1][2]};
    assign take    = shifted >= {1'b0, dvs[k-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        tag[k] <= '0;
      end else if (en) begin
        tag[k] <= tag[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= take ? 32'(shifted - {1'b0, dvs[k-1]}) : shifted[31:0];
        dvs[k]  <= dvs[k-1];
        mlow[k] <= {mlow[k-1][1:0], 1'b0};
        quo[k]  <= {quo[k-1][pt1k_pkg::QUO_W-2:0], take};
      end
    end
  end

  assign tag_out = tag[N];
  assign quo_out = quo[N];

endmodule

[design/pt1k_sqrt.sv]
// ----------------------------------------------------------------------------
// pt1k_sqrt
// pipelined integer square root, one root bit per stage, floor result
// ----------------------------------------------------------------------------
module pt1k_sqrt (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  pt1k_pkg::tag_t tag_in,
  input  logic [63:0]    x_in,
  output pt1k_pkg::tag_t tag_out,
  output logic [31:0]    root_out
);

  localparam int N = pt1k_pkg::SQRT_STEPS;

  pt1k_pkg::tag_t tag  [0:N];
  logic [63:0]    xs   [0:N];
  logic [33:0]    rem  [0:N];
  logic [31:0]    root [0:N];

  // load stage
  always_ff @(posedge clk) begin
    if (rst) begin
      tag[0] <= '0;
    end else if (en) begin
      tag[0] <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0]   <= x_in;
      rem[0]  <= '0;
      root[0] <= '0;
    end
  end

  // bring down two bits, try 4*root+1
  for (genvar k = 1; k <= N; k++) begin : g_step
    logic [35:0] cur;
    logic [35:0] trial;
    logic        take;

    assign cur   = {rem[k-1], xs[k-1][63:62]};
    assign trial = {2'b00, root[k-1], 2'b01};
    assign take  = cur >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        tag[k] <= '0;
      end else if (en) begin
        tag[k] <= tag[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= take ? 34'(cur - trial) : cur[33:0];
        root[k] <= {root[k-1][30:0], take};
        xs[k]   <= {xs[k-1][61:0], 2'b00};
      end
    end
  end

  assign tag_out  = tag[N];
  assign root_out = root[N];

endmodule

[design/pt1k_scale.sv]
// ----------------------------------------------------------------------------
// pt1k_scale
// turns the root into both temperatures, picks one by the window, saturates
// ----------------------------------------------------------------------------
module pt1k_scale (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  pt1k_pkg::tag_t     tag_in,
  input  logic [31:0]        s,
  input  logic signed [21:0] window_low,
  input  logic signed [21:0] window_high,
  output pt1k_pkg::tag_t     tag_out,
  output logic signed [21:0] temperature,
  output logic               second
);

  pt1k_pkg::tag_t tag1, tag2, tag3, tag4, tag5;

  // stage 1: root numerators and the pre-shifted dividend
  logic [32:0] mag_p, mag_m;
  logic        neg_p;
  logic [35:0] n_p, n_m;
  logic [29:0] p1_p, p1_m;
  logic        neg1;

  assign neg_p = s > pt1k_pkg::A16;
  assign mag_p = neg_p ? {1'b0, s - pt1k_pkg::A16} : {1'b0, pt1k_pkg::A16 - s};
  assign mag_m = {1'b0, pt1k_pkg::A16} + {1'b0, s};
  assign n_p   = {3'b000, mag_p} * 36'd5 + pt1k_pkg::ROUND_BIAS;
  assign n_m   = {3'b000, mag_m} * 36'd5 + pt1k_pkg::ROUND_BIAS;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_p <= n_p[35:6];
      p1_m <= n_m[35:6];
      neg1 <= neg_p;
    end
  end

  // stage 2: reciprocal multiply
  logic [60:0] prod_p, prod_m;
  logic [29:0] p2_p, p2_m;
  logic        neg2;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_p <= 61'(p1_p * pt1k_pkg::RECIP_K);
      prod_m <= 61'(p1_m * pt1k_pkg::RECIP_K);
      p2_p   <= p1_p;
      p2_m   <= p1_m;
      neg2   <= neg1;
    end
  end

  // stage 3: estimate quotient
  logic [22:0] qa_p, qa_m;
  logic [29:0] p3_p, p3_m;
  logic        neg3;

  always_ff @(posedge clk) begin
    if (en) begin
      qa_p <= prod_p[60:pt1k_pkg::RECIP_SHIFT];
      qa_m <= prod_m[60:pt1k_pkg::RECIP_SHIFT];
      p3_p <= p2_p;
      p3_m <= p2_m;
      neg3 <= neg2;
    end
  end

  // stage 4: remainder check, estimate is at most one low
  logic [30:0] r_p, r_m;
  logic [22:0] q4_p, q4_m;
  logic        neg4;

  assign r_p = {1'b0, p3_p} - 31'(qa_p * pt1k_pkg::DIV_CONST);
  assign r_m = {1'b0, p3_m} - 31'(qa_m * pt1k_pkg::DIV_CONST);

  always_ff @(posedge clk) begin
    if (en) begin
      q4_p <= (r_p >= 31'(pt1k_pkg::DIV_CONST)) ? qa_p + 23'd1 : qa_p;
      q4_m <= (r_m >= 31'(pt1k_pkg::DIV_CONST)) ? qa_m + 23'd1 : qa_m;
      neg4 <= neg3;
    end
  end

  // stage 5: sign, window test, select, saturate
  logic signed [23:0] t_p, t_m, t_sel, lo24, hi24;
  logic               in_window;
  logic signed [21:0] t_sat;

  always_comb begin
    t_p       = neg4 ? -$signed({1'b0, q4_p}) : $signed({1'b0, q4_p});
    t_m       = $signed({1'b0, q4_m});
    lo24      = 24'(window_low);
    hi24      = 24'(window_high);
    in_window = (t_p > lo24) && (t_p < hi24);
    t_sel     = in_window ? t_p : t_m;
    priority if (t_sel > pt1k_pkg::T22_MAX) begin
      t_sat = 22'(pt1k_pkg::T22_MAX);
    end else if (t_sel < pt1k_pkg::T22_MIN) begin
      t_sat = 22'(pt1k_pkg::T22_MIN);
    end else begin
      t_sat = t_sel[21:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      temperature <= tag4.bad ? '0 : t_sat;
      second      <= !tag4.bad && !in_window;
    end
  end

  // tags
  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
      tag2 <= '0;
      tag3 <= '0;
      tag4 <= '0;
      tag5 <= '0;
    end else if (en) begin
      tag1 <= tag_in;
      tag2 <= tag1;
      tag3 <= tag2;
      tag4 <= tag3;
      tag5 <= tag4;
    end
  end

  assign tag_out = tag5;

endmodule

[design/pt1000_resistance_ratio_to_temperature_unit.sv]
// ----------------------------------------------------------------------------
// pt1000_resistance_ratio_to_temperature_unit
// inverse callendar-van dusen for a pt1000 from two measured times
//
//   channel   dir  handshake      contents
//   sample    in   valid/ready    measured_time, reference_time
//   result    out  valid/ready    temperature_q8, second_root_used, invalid
//   cfg       in   cfg_we         cfg_index, cfg_data (window bounds)
//
// one request per cycle while the pipeline advances; the result leaves after 73 register
// stages, most of them in the 32-stage ratio divider and the 33-stage square root
// the whole pipeline advances when the result slot is empty or taken
// rst clears all valid bits and loads the default window 0 .. 200 degrees
// ----------------------------------------------------------------------------
module pt1000_resistance_ratio_to_temperature_unit (
  input  logic               clk,
  input  logic               rst,
  pt1k_in_if.sink            sample,
  pt1k_out_if.source         result,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [21:0]        cfg_data
);

  logic en;

  // global advance
  assign en           = !result.valid || result.ready;
  assign sample.ready = en;

  // window registers
  logic signed [21:0] window_low, window_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_low  <= '0;
      window_high <= 22'sd51200;
    end else if (cfg_we) begin
      unique case (pt1k_pkg::cfg_index_t'(cfg_index))
        pt1k_pkg::CFG_WINDOW_LOW:  window_low  <= cfg_data;
        pt1k_pkg::CFG_WINDOW_HIGH: window_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // input stage: range check on the ratio
  pt1k_pkg::tag_t a_tag;
  logic [31:0]    a_m, a_ref;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_tag <= '0;
    end else if (en) begin
      a_tag.valid <= sample.valid;
      a_tag.bad   <= (sample.reference_time == 32'd0) ||
                     ({3'b000, sample.measured_time} >= {sample.reference_time, 3'b000});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_m   <= sample.measured_time;
      a_ref <= sample.reference_time;
    end
  end

  // ratio
  pt1k_pkg::tag_t              d_tag;
  logic [pt1k_pkg::QUO_W-1:0]  d_quo;

  pt1k_divider u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .tag_in  (a_tag),
    .m       (a_m),
    .ref_val (a_ref),
    .tag_out (d_tag),
    .quo_out (d_quo)
  );

  // discriminant slope product
  pt1k_pkg::tag_t b_tag;
  logic [58:0]    b_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_tag <= '0;
    end else if (en) begin
      b_tag <= d_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_prod <= 59'(d_quo * pt1k_pkg::DISC_SLOPE);
    end
  end

  // discriminant, negative marks the request bad
  pt1k_pkg::tag_t c_tag;
  logic [63:0]    c_x;
  logic [63:0]    sub;

  assign sub = {1'b0, b_prod, 4'b0000};

  always_ff @(posedge clk) begin
    if (rst) begin
      c_tag <= '0;
    end else if (en) begin
      c_tag.valid <= b_tag.valid;
      c_tag.bad   <= b_tag.bad || (sub > pt1k_pkg::DISC_BASE);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_x <= pt1k_pkg::DISC_BASE - sub;
    end
  end

  // root of the discriminant
  pt1k_pkg::tag_t r_tag;
  logic [31:0]    r_s;

  pt1k_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .tag_in   (c_tag),
    .x_in     (c_x),
    .tag_out  (r_tag),
    .root_out (r_s)
  );

  // temperature and output register
  pt1k_pkg::tag_t o_tag;

  pt1k_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .tag_in      (r_tag),
    .s           (r_s),
    .window_low  (window_low),
    .window_high (window_high),
    .tag_out     (o_tag),
    .temperature (result.temperature_q8),
    .second      (result.second_root_used)
  );

  assign result.valid   = o_tag.valid;
  assign result.invalid = o_tag.bad;

endmodule

[design/pt1k_checker.sv]
// ----------------------------------------------------------------------------
// pt1k_checker
// port-level checks on the temperature unit
// ----------------------------------------------------------------------------
`include "pt1000_resistance_ratio_to_temperature_unit_macros.svh"

module pt1k_checker (
  input logic               clk,
  input logic               rst,
  input logic               s_ready,
  input logic               r_valid,
  input logic               r_ready,
  input logic signed [21:0] r_temp,
  input logic               r_second,
  input logic               r_invalid
);

  // invalid results carry zero and no root flag
  `PT1K_ASSERT_NOW(a_invalid_zero, r_valid && r_invalid, r_temp == 22'sd0 && !r_second)

  // input side advances exactly when the result slot frees
  `PT1K_ASSERT_NOW(a_ready_link, 1'b1, s_ready == (!r_valid || r_ready))

  // a stalled result holds
  `PT1K_ASSERT_NEXT(a_hold, r_valid && !r_ready,
                    r_valid && $stable(r_temp) && $stable(r_second) && $stable(r_invalid))

  // pipeline comes out of reset empty
  `PT1K_ASSERT_NOW(a_reset_empty, $past(rst), !r_valid)

endmodule

bind pt1000_resistance_ratio_to_temperature_unit pt1k_checker u_pt1k_checker (
  .clk      (clk),
  .rst      (rst),
  .s_ready  (sample.ready),
  .r_valid  (result.valid),
  .r_ready  (result.ready),
  .r_temp   (result.temperature_q8),
  .r_second (result.second_root_used),
  .r_invalid(result.invalid)
);
